// ----- design/log_segment_block_allocator_assert.svh -----
// Assertion macros for the log segment block allocator
`ifndef LOG_SEGMENT_BLOCK_ALLOCATOR_ASSERT_SVH
`define LOG_SEGMENT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define LSBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("log segment allocator check failed");

// next-cycle implication
`define LSBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("log segment allocator check failed");

`endif

// ----- design/lsba_pkg.sv -----
// Types and constants shared by the log segment block allocator
`timescale 1ns / 1ps

package lsba_pkg;

  localparam int DISK_BLOCKS_DEF    = 4096;
  localparam int SEGMENT_BLOCKS_DEF = 8;
  localparam int RESERVED_BLOCKS    = 8;

  localparam int BLK_W  = 12;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 13;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_FREE   = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_FLUSH  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [BLK_W-1:0]  block_no;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0]  assigned_block;
    logic              flushed;
    logic [BLK_W-1:0]  flush_base;
    logic              in_segment;
    logic [SLOT_W-1:0] segment_slot;
    logic              was_allocated;
    logic [CNT_W-1:0]  allocated_count;
  } out_item_t;

endpackage

// ----- design/log_segment_block_allocator.sv -----
// Log segment block allocator: free bitmap memory, log head and open segment fill
//
// Input channel in_valid / in_stall / in_data carries one transaction: a kind
// (append, free, lookup, flush) and a block number. Result channel out_valid /
// out_stall / out_data returns exactly one result transaction per input.
// An accepted transaction reads the free bitmap memory (two read ports: the
// given block and the append address) in the accept cycle and writes the
// updated bit back when it commits from S_EXEC, as the result is loaded into
// the output register. out_valid rises on that commit. No new transaction is
// taken until the previous one has committed, the bitmap read being registered
// ahead of the bit update. in_stall stays low while a finished result waits in
// the output register, so the next transaction is read while it is held.
// Reset (rst_n low, synchronous) sets the log head to SEGMENT_BLOCKS, the
// fill index to zero and the count to eight, then runs a clearing pass over
// the bitmap, one block a cycle, with in_stall high.
// A stalled result is held in the output register; a finished transaction
// waits for it to drain before it commits.
`timescale 1ns / 1ps
`include "log_segment_block_allocator_assert.svh"

module log_segment_block_allocator #(
  parameter int DISK_BLOCKS    = lsba_pkg::DISK_BLOCKS_DEF,
  parameter int SEGMENT_BLOCKS = lsba_pkg::SEGMENT_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsba_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lsba_pkg::out_item_t out_data
);

  localparam int MAW    = $clog2(DISK_BLOCKS);
  localparam int AW_RAW = $clog2(DISK_BLOCKS + 2 * SEGMENT_BLOCKS + 1);
  localparam int AW     = (AW_RAW > lsba_pkg::BLK_W) ? AW_RAW : lsba_pkg::BLK_W;
  localparam int FW     = $clog2(SEGMENT_BLOCKS + 1);
  localparam int CW     = $clog2(DISK_BLOCKS + 1);
  localparam int OCW    = (CW > lsba_pkg::CNT_W) ? CW : lsba_pkg::CNT_W;

  logic mem [DISK_BLOCKS];

  lsba_pkg::state_t     state_r, state_nxt;
  logic [MAW-1:0]       clr_r, clr_nxt;
  logic [AW-1:0]        head_r, head_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        used_r, used_nxt;
  lsba_pkg::kind_t      kind_r;
  logic [AW-1:0]        blk_r;
  logic                 rd_a_r, rd_b_r;
  logic                 out_valid_r, out_valid_nxt;
  lsba_pkg::out_item_t  out_data_r, out_data_nxt;

  logic                 in_acc, commit;
  logic                 seg_full, app_flush, addr_ok, blk_ok, was;
  logic [AW-1:0]        next_head, app_head, addr, in_blk, slot_diff;
  logic [FW-1:0]        app_fill;
  logic [OCW-1:0]       cnt_wide;
  logic                 mem_we, mem_wd;
  logic [MAW-1:0]       mem_wa;

  assign in_stall  = (state_r != lsba_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign commit    = (state_r == lsba_pkg::S_EXEC) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_blk    = AW'(in_data.block_no);
  assign seg_full  = (fill_r >= FW'(SEGMENT_BLOCKS));
  assign next_head = (head_r + AW'(2 * SEGMENT_BLOCKS) > AW'(DISK_BLOCKS)) ?
                     AW'(SEGMENT_BLOCKS) : head_r + AW'(SEGMENT_BLOCKS);
  assign app_flush = seg_full;
  assign app_head  = app_flush ? next_head : head_r;
  assign app_fill  = app_flush ? '0 : fill_r;
  assign addr      = app_head + AW'(app_fill);
  assign addr_ok   = (addr < AW'(DISK_BLOCKS));
  assign blk_ok    = (blk_r < AW'(DISK_BLOCKS));
  assign was       = blk_ok && !rd_a_r;
  assign slot_diff = blk_r - head_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (in_acc) begin
      rd_a_r <= mem[in_blk[MAW-1:0]];
      rd_b_r <= mem[addr[MAW-1:0]];
      kind_r <= in_data.kind;
      blk_r  <= in_blk;
    end
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = clr_r;
    mem_wd        = (clr_r >= MAW'(lsba_pkg::RESERVED_BLOCKS));
    cnt_wide      = '0;

    unique case (state_r)
      lsba_pkg::S_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + MAW'(1);
        if (clr_r == MAW'(DISK_BLOCKS - 1)) begin
          state_nxt = lsba_pkg::S_IDLE;
        end
      end
      lsba_pkg::S_IDLE: begin
        if (in_acc) begin
          state_nxt = lsba_pkg::S_EXEC;
        end
      end
      lsba_pkg::S_EXEC: begin
        if (commit) begin
          out_data_nxt = '0;
          out_data_nxt.was_allocated = was;
          unique case (kind_r)
            lsba_pkg::KIND_APPEND: begin
              out_data_nxt.assigned_block = addr[lsba_pkg::BLK_W-1:0];
              out_data_nxt.flushed        = app_flush;
              out_data_nxt.flush_base     = app_flush ? head_r[lsba_pkg::BLK_W-1:0] : '0;
              head_nxt = app_head;
              fill_nxt = app_fill + FW'(1);
              if (addr_ok && rd_b_r) begin
                mem_we   = 1'b1;
                mem_wa   = addr[MAW-1:0];
                mem_wd   = 1'b0;
                used_nxt = used_r + CW'(1);
              end
            end
            lsba_pkg::KIND_FREE: begin
              if (was) begin
                mem_we   = 1'b1;
                mem_wa   = blk_r[MAW-1:0];
                mem_wd   = 1'b1;
                used_nxt = used_r - CW'(1);
              end
            end
            lsba_pkg::KIND_LOOKUP: begin
              if (blk_r >= head_r && blk_r < head_r + AW'(fill_r)) begin
                out_data_nxt.in_segment   = 1'b1;
                out_data_nxt.segment_slot = slot_diff[lsba_pkg::SLOT_W-1:0];
              end
            end
            lsba_pkg::KIND_FLUSH: begin
              out_data_nxt.flushed    = 1'b1;
              out_data_nxt.flush_base = head_r[lsba_pkg::BLK_W-1:0];
              head_nxt = next_head;
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
          cnt_wide = OCW'(used_nxt);
          out_data_nxt.allocated_count = cnt_wide[lsba_pkg::CNT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = lsba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = lsba_pkg::S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lsba_pkg::S_CLEAR;
      clr_r       <= '0;
      head_r      <= AW'(SEGMENT_BLOCKS);
      fill_r      <= '0;
      used_r      <= CW'(lsba_pkg::RESERVED_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `LSBA_ASSERT_NOW(a_fill_range, 1'b1, fill_r <= FW'(SEGMENT_BLOCKS))
  `LSBA_ASSERT_NOW(a_count_range, 1'b1, used_r <= CW'(DISK_BLOCKS))
  `LSBA_ASSERT_NOW(a_head_floor, 1'b1, head_r >= AW'(SEGMENT_BLOCKS))
  `LSBA_ASSERT_NOW(a_write_owner, mem_we, state_r == lsba_pkg::S_CLEAR || commit)
  `LSBA_ASSERT_NEXT(a_accept_exec, in_acc, state_r == lsba_pkg::S_EXEC)
  `LSBA_ASSERT_NEXT(a_commit_result, commit, out_valid_r && state_r == lsba_pkg::S_IDLE)

endmodule
